FILE: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

	// input item layout (tdata, lowest bit first)
	localparam int ACTION_W     = 3;
	localparam int IN_WORD_W    = 32;
	localparam int IN_TDATA_W   = 40;

	// result item layout (tdata, lowest bit first)
	localparam int OUT_WORD_W   = 32;
	localparam int OUT_COUNT_W  = 11;
	localparam int STATUS_W     = 2;
	localparam int OUT_TDATA_W  = 112;

	typedef enum logic [ACTION_W-1:0] {
		ACT_QUERY      = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_PUSH_FRONT = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_POP_BACK   = 3'd4
	} deq_action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} deq_status_t;

	// per-step control broadcast along one chain
	typedef struct packed {
		logic push_end;   // insert at cell 0, everything moves one cell further
		logic pop_end;    // drop cell 0, everything moves one cell closer
		logic load_far;   // write the word into the cell just past the last live one
	} deq_ctl_t;

endpackage

FILE: rtl/core/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell
	import deq_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 11,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  deq_ctl_t              ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic [DATA_WIDTH-1:0] next_data,
	output logic [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  at_tail;

	assign at_tail = (count == CNT_W'(INDEX));
	assign data    = data_q;

	always_ff @(posedge clk) begin
		priority if (ctl.push_end) begin
			data_q <= prev_data;
		end else if (ctl.pop_end) begin
			data_q <= next_data;
		end else if (ctl.load_far && at_tail) begin
			data_q <= word;
		end else begin
			data_q <= data_q;
		end
	end

endmodule

FILE: rtl/core/deq_chain.sv
`timescale 1ns / 1ps

module deq_chain
	import deq_pkg::*;
#(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 11
) (
	input  logic                  clk,
	input  deq_ctl_t              ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [DATA_WIDTH-1:0] word,
	output logic [DATA_WIDTH-1:0] end_data,
	output logic [DATA_WIDTH-1:0] second_data
);

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_d;
		logic [DATA_WIDTH-1:0] next_d;

		if (i == 0) begin : g_first
			assign prev_d = word;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_d = cell_data[i];
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end

		deq_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CNT_W     (CNT_W),
			.INDEX     (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count),
			.word     (word),
			.prev_data(prev_d),
			.next_data(next_d),
			.data     (cell_data[i])
		);
	end

	assign end_data    = cell_data[0];
	assign second_data = cell_data[1];

endmodule

FILE: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps

// double-ended queue of words held in two mirrored rows of DEPTH register cells.
// the front row keeps the front word in cell 0, the back row keeps the back word
// in cell 0; a push or pop at one end shifts that end's row by one cell while the
// other row writes or forgets the word at the far end of the live run. every
// input item (query, push back, push front, pop front, pop back) gives exactly
// one result item: the popped word, the front and back words after the step,
// the count, an empty flag and a status. a push on a full queue is dropped with
// status 2; a pop on an empty queue returns -1 with status 1; action codes 5..7
// act as a query. the result is registered: it appears in the cycle after the item
// is accepted, and one item is taken every cycle as long as the result register
// is empty or being read in the same cycle, so the output side's tready sets the
// sustained rate. no clearing pass is needed after reset; only live cells are read.
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [2:0] action, [34:3] push_value, [39:35] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [31:0] taken_value, [63:32] front_value, [95:64] back_value,
	// [106:96] item_count, [107] is_empty, [109:108] status, [111:110] zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int EXT_W = (DATA_WIDTH > OUT_WORD_W) ? DATA_WIDTH : OUT_WORD_W;
	localparam int PAD_W = OUT_TDATA_W - 3 * OUT_WORD_W - OUT_COUNT_W - 1 - STATUS_W;
	localparam int CW_EXT = (CNT_W > OUT_COUNT_W) ? CNT_W : OUT_COUNT_W;

	// control state
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// input fields
	logic [ACTION_W-1:0]   action;
	logic [IN_WORD_W-1:0]  push_value;
	logic [EXT_W-1:0]      push_ext;
	logic [DATA_WIDTH-1:0] word;
	logic [DATA_WIDTH-1:0] none_word;

	logic fire;
	logic is_full, is_zero;
	logic push_b, push_f, pop_f, pop_b, pop_none, push_none;
	logic [CNT_W-1:0] count_d;

	deq_ctl_t fwd_ctl, rev_ctl;
	logic [DATA_WIDTH-1:0] fwd0, fwd1, rev0, rev1;

	logic [DATA_WIDTH-1:0] taken_w, front_w, back_w;
	logic [EXT_W-1:0]      taken_x, front_x, back_x;
	logic [CW_EXT-1:0]     count_x;
	deq_status_t           status_d;

	assign action     = s_tdata[ACTION_W-1:0];
	assign push_value = s_tdata[ACTION_W +: IN_WORD_W];
	assign push_ext   = EXT_W'(push_value);
	assign word       = push_ext[DATA_WIDTH-1:0];
	assign none_word  = '1;

	// a new item goes in whenever the result register is free or draining
	assign s_tready = !out_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;

	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_zero = (count_q == '0);

	// decode the action; unknown codes fall through as a query
	always_comb begin
		push_b    = 1'b0;
		push_f    = 1'b0;
		pop_f     = 1'b0;
		pop_b     = 1'b0;
		pop_none  = 1'b0;
		push_none = 1'b0;
		unique case (action)
			ACT_PUSH_BACK: begin
				push_b    = !is_full;
				push_none = is_full;
			end
			ACT_PUSH_FRONT: begin
				push_f    = !is_full;
				push_none = is_full;
			end
			ACT_POP_FRONT: begin
				pop_f    = !is_zero;
				pop_none = is_zero;
			end
			ACT_POP_BACK: begin
				pop_b    = !is_zero;
				pop_none = is_zero;
			end
			default: begin
			end
		endcase
	end

	// front row: push front shifts it, push back lands at the far end
	assign fwd_ctl.push_end = fire && push_f;
	assign fwd_ctl.pop_end  = fire && pop_f;
	assign fwd_ctl.load_far = fire && push_b;
	// back row: mirror image
	assign rev_ctl.push_end = fire && push_b;
	assign rev_ctl.pop_end  = fire && pop_b;
	assign rev_ctl.load_far = fire && push_f;

	deq_chain #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH),
		.CNT_W     (CNT_W)
	) u_front_row (
		.clk        (clk),
		.ctl        (fwd_ctl),
		.count      (count_q),
		.word       (word),
		.end_data   (fwd0),
		.second_data(fwd1)
	);

	deq_chain #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH),
		.CNT_W     (CNT_W)
	) u_back_row (
		.clk        (clk),
		.ctl        (rev_ctl),
		.count      (count_q),
		.word       (word),
		.end_data   (rev0),
		.second_data(rev1)
	);

	// count after the step
	always_comb begin
		priority if (push_b || push_f) begin
			count_d = count_q + CNT_W'(1);
		end else if (pop_f || pop_b) begin
			count_d = count_q - CNT_W'(1);
		end else begin
			count_d = count_q;
		end
	end

	// result fields, taken from what the rows will hold after the step
	always_comb begin
		priority if (pop_f) begin
			taken_w = fwd0;
		end else if (pop_b) begin
			taken_w = rev0;
		end else if (pop_none) begin
			taken_w = none_word;
		end else begin
			taken_w = '0;
		end

		priority if (count_d == '0) begin
			front_w = none_word;
		end else if (push_f || (push_b && is_zero)) begin
			front_w = word;
		end else if (pop_f) begin
			front_w = fwd1;
		end else begin
			front_w = fwd0;
		end

		priority if (count_d == '0) begin
			back_w = none_word;
		end else if (push_b || (push_f && is_zero)) begin
			back_w = word;
		end else if (pop_b) begin
			back_w = rev1;
		end else begin
			back_w = rev0;
		end

		priority if (pop_none) begin
			status_d = ST_POP_EMPTY;
		end else if (push_none) begin
			status_d = ST_PUSH_FULL;
		end else begin
			status_d = ST_OK;
		end
	end

	assign taken_x = EXT_W'(taken_w);
	assign front_x = EXT_W'(front_w);
	assign back_x  = EXT_W'(back_w);
	assign count_x = CW_EXT'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {PAD_W'(0), status_d, (count_d == '0),
				count_x[OUT_COUNT_W-1:0], back_x[OUT_WORD_W-1:0],
				front_x[OUT_WORD_W-1:0], taken_x[OUT_WORD_W-1:0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// the count never passes the capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("deque count above capacity");

	// an accepted push with room grows the count by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (push_b || push_f) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not grow the count");

	// a pop on an empty queue leaves it empty and reports it
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pop_none |=> count_q == '0 && m_tvalid
			&& m_tdata[OUT_TDATA_W-PAD_W-1 -: STATUS_W] == ST_POP_EMPTY)
		else $error("pop on empty queue mishandled");

	// the empty flag of a shown result agrees with its count field
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3*OUT_WORD_W+OUT_COUNT_W]
			== (m_tdata[3*OUT_WORD_W +: OUT_COUNT_W] == '0) || CNT_W > OUT_COUNT_W)
		else $error("empty flag disagrees with count");

endmodule

FILE: sim/double_ended_queue_tb.sv
`timescale 1ns / 1ps

// stream testbench for the double-ended queue: a scoreboard keeps its own ring
// of words and predicts one result item per accepted item, the driver sends a
// short directed run, then mixed traffic, a fill to full and traffic near full
module double_ended_queue_tb;
	import deq_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 32;

	// spare action codes, the block treats them as a query
	localparam logic [ACTION_W-1:0] ACT_SPARE_LO  = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_MID = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_HI  = 3'd7;

	// words that mean "nothing there" in the result
	localparam logic [OUT_WORD_W-1:0] NO_WORD = '1;

	typedef struct {
		logic [OUT_WORD_W-1:0]  taken;
		logic [OUT_WORD_W-1:0]  front;
		logic [OUT_WORD_W-1:0]  back;
		logic [OUT_COUNT_W-1:0] count;
		logic                   empty;
		deq_status_t            status;
	} deq_result_t;

	// scoreboard: shadow ring plus the list of results still owed by the block
	class deque_scoreboard;
		logic [DATA_WIDTH-1:0] words [DEPTH];
		int unsigned head;
		int unsigned held;
		deq_result_t owed_q[$];
		int errors;
		int checked;
		int peak;
		int pushes;
		int pops;
		int queries;
		int full_pushes;
		int empty_pops;

		function void note_item(logic [ACTION_W-1:0] act, logic [IN_WORD_W-1:0] val);
			deq_result_t r;
			r.taken  = '0;
			r.status = ST_OK;
			case (act)
				ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
					pushes++;
					if (held == DEPTH) begin
						// full: the word is dropped
						r.status = ST_PUSH_FULL;
						full_pushes++;
					end else if (act == ACT_PUSH_BACK) begin
						words[(head + held) % DEPTH] = val;
						held++;
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						words[head] = val;
						held++;
					end
				end
				ACT_POP_FRONT, ACT_POP_BACK: begin
					pops++;
					if (held == 0) begin
						r.taken  = NO_WORD;
						r.status = ST_POP_EMPTY;
						empty_pops++;
					end else if (act == ACT_POP_FRONT) begin
						r.taken = words[head];
						head = (head + 1) % DEPTH;
						held--;
					end else begin
						r.taken = words[(head + held - 1) % DEPTH];
						held--;
					end
				end
				default: queries++;
			endcase
			if (held == 0) begin
				r.front = NO_WORD;
				r.back  = NO_WORD;
			end else begin
				r.front = words[head];
				r.back  = words[(head + held - 1) % DEPTH];
			end
			r.count = OUT_COUNT_W'(held);
			r.empty = (held == 0);
			if (held > peak)
				peak = held;
			owed_q.insert(owed_q.size(), r);
		endfunction

		function void compare_field(string name, logic [OUT_WORD_W-1:0] want,
				logic [OUT_WORD_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %h, got %h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] data);
			deq_result_t r;
			if (owed_q.size() == 0) begin
				$error("result item with nothing pending: %h", data);
				errors++;
				return;
			end
			r = owed_q[0];
			owed_q.delete(0);
			checked++;
			compare_field("taken_value", r.taken, data[31:0]);
			compare_field("front_value", r.front, data[63:32]);
			compare_field("back_value", r.back, data[95:64]);
			compare_field("item_count", OUT_WORD_W'(r.count), OUT_WORD_W'(data[106:96]));
			compare_field("is_empty", OUT_WORD_W'(r.empty), OUT_WORD_W'(data[107]));
			compare_field("status", OUT_WORD_W'(r.status), OUT_WORD_W'(data[109:108]));
		endfunction
	endclass

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// when set, neither side idles
	logic steady = 1'b0;

	deque_scoreboard sb = new();

	double_ended_queue #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// output side: tready is low with a chance of 8 in a hundred unless steady
	always @(posedge clk) begin
		m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 8);
	end

	// result items are checked at the edge that moves them
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// one item: optional idle cycles, then hold valid until the block takes it;
	// valid stays high on return so back-to-back items keep flowing
	task automatic send_item(input logic [ACTION_W-1:0] act,
			input logic [IN_WORD_W-1:0] val);
		while (!steady && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - ACTION_W - IN_WORD_W){1'b0}}, val, act};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(act, val);
	endtask

	// stop sending and wait for every owed result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
	endtask

	// random item with the given percentages of pushes and pops, the rest queries
	// and now and then a spare code
	task automatic send_random(input int push_pct, input int pop_pct);
		int r;
		logic [ACTION_W-1:0] act;
		r = $urandom_range(99);
		if (r < push_pct)
			act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
		else if (r < push_pct + pop_pct)
			act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
		else if (r < 96)
			act = ACT_QUERY;
		else
			act = ACTION_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
		send_item(act, $urandom());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue corner cases and spare codes
		send_item(ACT_POP_FRONT, 32'h0000_0000);
		send_item(ACT_POP_BACK, 32'hffff_ffff);
		send_item(ACT_QUERY, 32'h1234_5678);
		send_item(ACT_SPARE_LO, 32'h5555_5555);
		send_item(ACT_SPARE_MID, 32'haaaa_aaaa);
		send_item(ACT_SPARE_HI, 32'hffff_ffff);
		// extreme words at both ends, front push wraps the head below zero
		send_item(ACT_PUSH_BACK, 32'h7fff_ffff);
		send_item(ACT_PUSH_FRONT, 32'h8000_0000);
		send_item(ACT_PUSH_BACK, 32'h0000_0000);
		send_item(ACT_PUSH_FRONT, 32'hffff_ffff);
		send_item(ACT_QUERY, 32'h0000_0000);
		send_item(ACT_SPARE_HI, 32'hdead_beef);
		send_item(ACT_POP_BACK, 32'h0000_0000);
		send_item(ACT_POP_FRONT, 32'h0000_0000);
		send_item(ACT_POP_FRONT, 32'h0000_0000);
		send_item(ACT_POP_BACK, 32'h0000_0000);
		send_item(ACT_POP_BACK, 32'h0000_0000);
		// single word: front and back are the same word
		send_item(ACT_PUSH_FRONT, 32'h0000_0001);
		send_item(ACT_POP_BACK, 32'h0000_0000);
		send_item(ACT_PUSH_BACK, 32'hffff_fffe);
		send_item(ACT_POP_FRONT, 32'h0000_0000);
		send_item(ACT_POP_FRONT, 32'h0000_0000);

		// sender holds off until the block has caught up
		drain_results();

		// mixed traffic around a small fill, many pops on empty
		repeat (16)
			send_random(45, 45);

		// fill to full with no idling on either side, then pushes on full
		steady = 1'b1;
		while (sb.held < DEPTH)
			send_random(100, 0);
		send_item(ACT_PUSH_BACK, $urandom());
		send_item(ACT_QUERY, $urandom());
		send_item(ACT_PUSH_FRONT, $urandom());
		send_item(ACT_PUSH_BACK, $urandom());
		steady = 1'b0;

		// traffic near full
		repeat (16)
			send_random(50, 44);

		drain_results();
		repeat (8) @(posedge clk);

		$display("items: %0d pushes, %0d pops, %0d queries or spare codes; peak fill %0d of %0d",
			sb.pushes, sb.pops, sb.queries, sb.peak, DEPTH);
		$display("%0d pushes on full, %0d pops on empty, %0d results checked",
			sb.full_pushes, sb.empty_pops, sb.checked);
		if (sb.errors == 0) begin
			$display("double_ended_queue_tb passed");
		end else begin
			$display("double_ended_queue_tb failed");
		end
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#2_000_000;
		$display("double_ended_queue_tb failed");
		$finish;
	end

endmodule
